// ===== src/pts_pkg.sv =====
package pts_pkg;

    // Configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 64;

    localparam logic [CFG_IW-1:0] REG_PATTERN_LO = 3'd0;
    localparam logic [CFG_IW-1:0] REG_PATTERN_HI = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CONTROL    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_CHANCE     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_LAP_DIV    = 3'd4;

    localparam logic [63:0] RST_PATTERN_LO = 64'd1;
    localparam logic [63:0] RST_PATTERN_HI = 64'd10;
    localparam logic [4:0]  RST_CONTROL    = 5'd1;
    localparam logic [11:0] RST_CHANCE     = 12'd1417;
    localparam logic [11:0] RST_LAP_DIV    = 12'd1074;

    // Output modes (control bits 2:1)
    localparam logic [1:0] MODE_GATE       = 2'd0;
    localparam logic [1:0] MODE_ONEHOT     = 2'd1;
    localparam logic [1:0] MODE_VALUE      = 2'd2;
    localparam logic [1:0] MODE_ONEHOT_ALT = 2'd3;

    // Cell kinds
    localparam logic [3:0] KIND_OFF      = 4'd0;
    localparam logic [3:0] KIND_ON       = 4'd1;
    localparam logic [3:0] KIND_CHANCE_A = 4'd2;
    localparam logic [3:0] KIND_CHANCE_B = 4'd3;
    localparam logic [3:0] KIND_CHANCE_C = 4'd4;
    localparam logic [3:0] KIND_COIN     = 4'd5;
    localparam logic [3:0] KIND_SLICE    = 4'd6;
    localparam logic [3:0] KIND_LAP_A    = 4'd7;
    localparam logic [3:0] KIND_LAP_B    = 4'd8;
    localparam logic [3:0] KIND_LAP_C    = 4'd9;
    localparam logic [3:0] CELL_END      = 4'd10;

    // Levels in tenths of a volt and fixed-point thresholds
    localparam logic [6:0]  LVL_OFF      = 7'd0;
    localparam logic [6:0]  LVL_ON       = 7'd100;
    localparam logic [6:0]  LVL_SCALE    = 7'd10;
    localparam logic [19:0] COIN_THRESH  = 20'd393216;   // 0.60 * 10 * 65536
    localparam logic [15:0] FALL_THRESH  = 16'd32768;    // 0.50 * 65536
    localparam logic [19:0] TENTHS_SCALE = 20'd10;
    localparam logic [2:0]  DIGIT_MAX    = 3'd6;
    localparam logic [6:0]  DIGIT_BASE   = 7'd3;

    localparam int CELLS_STORED = 32;

endpackage

// ===== src/probabilistic_trigger_sequencer.sv =====
// Probabilistic trigger step sequencer.
// One input beat per sample tick on the s_axis channel carries the clock and
// reset levels, a 16-bit random fraction, a random digit and the left
// neighbour's gate state. Each accepted beat produces exactly one output beat
// on m_axis with the held output levels: main level, kind one-hot, cell
// value, step number and the loop-start flag.
// A rising clock level advances through up to 32 four-bit cells; a cell of 10
// ends the pattern, after which the sequencer wraps or stops.
// A single output register follows the state update: one beat per cycle.
// While the output beat waits (m_axis_tready low), one more input beat is not
// taken; tready on s_axis reopens in the same cycle the output is taken.
// Configuration is a plain write port (enable, index, data), which the user
// must write only while the stream is idle; the block does not enforce it.
// Reset (i_rst_n low, synchronous) restores the default pattern and controls,
// puts the sequencer before its first step, clears the lap counters and held
// outputs, and empties the output register.
module probabilistic_trigger_sequencer
    import pts_pkg::*;
#(
    parameter int STEPS       = 32,
    parameter int SLICE_TICKS = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write port
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    // input stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [0] clock_level, [1] reset_level, [17:2] random_fraction,
    // [20:18] random_digit, [21] neighbour_gate_high
    input  logic [23:0]       i_s_axis_tdata,
    // output stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [6:0] main_level, [15:7] kind_one_hot, [19:16] cell_value,
    // [24:20] step_number, [25] loop_start
    output logic [31:0]       o_m_axis_tdata
);

    localparam int PW = $clog2(STEPS + 1);
    localparam int SW = $clog2(SLICE_TICKS + 1);

    // Configuration registers
    logic [63:0] r_pat_lo;
    logic [63:0] r_pat_hi;
    logic [4:0]  r_ctrl;
    logic [11:0] r_chance;
    logic [11:0] r_lap_div;

    // Sequencer state
    logic          r_clk_prev, n_clk_prev;
    logic          r_rst_prev, n_rst_prev;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_before, n_before;
    logic          r_stopped, n_stopped;
    logic [2:0]    r_lap [3];
    logic [2:0]    n_lap [3];
    logic [SW-1:0] r_slice, n_slice;

    // Held outputs
    logic [6:0] r_main, n_main;
    logic [8:0] r_onehot, n_onehot;
    logic [3:0] r_value, n_value;
    logic [4:0] r_step, n_step;
    logic       r_loop, n_loop;
    logic       r_out_valid;

    logic accept;

    // Unpacked input beat
    logic        in_clk, in_rst, in_nb;
    logic [15:0] in_rnd;
    logic [2:0]  in_dig;

    assign in_clk = i_s_axis_tdata[0];
    assign in_rst = i_s_axis_tdata[1];
    assign in_rnd = i_s_axis_tdata[17:2];
    assign in_dig = i_s_axis_tdata[20:18];
    assign in_nb  = i_s_axis_tdata[21];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_loop, r_step, r_value, r_onehot, r_main};

    // Cell at a step index; indexes past the stored cells read 0
    function automatic logic [3:0] cell_at(input logic [PW-1:0] p,
                                           input logic [127:0] pat);
        logic [6:0] e;
        e = 7'(p);
        if (e >= 7'(CELLS_STORED)) return 4'd0;
        return pat[{e[4:0], 2'b00} +: 4];
    endfunction

    function automatic logic [4:0] step_low(input logic [PW-1:0] p);
        logic [6:0] e;
        e = 7'(p);
        return e[4:0];
    endfunction

    function automatic logic [3:0] nib(input logic [11:0] w, input logic [1:0] sel);
        return w[{sel, 2'b00} +: 4];
    endfunction

    function automatic logic [8:0] onehot_of(input logic [3:0] v);
        if (v >= KIND_ON && v <= KIND_LAP_C) return 9'd1 << (v - KIND_ON);
        return 9'd0;
    endfunction

    // Next state and held outputs for one beat
    always_comb begin
        logic          rise, fall, rrise;
        logic          loop_en, hold, choke, onehot_mode;
        logic [1:0]    mode;
        logic [2:0]    dig_c;
        logic [127:0]  pat;
        logic [3:0]    c_cur, cell0, c1, v_rise, v, v_after, d, dabs;
        logic [PW-1:0] nx, p1, p2;
        logic          st1, st2, end_hit;
        logic [3:0]    cnt;
        logic [2:0]    lap_rise [3];
        logic [1:0]    sel;
        logic [6:0]    lvl;

        pat         = {r_pat_hi, r_pat_lo};
        rise        = !r_clk_prev && in_clk;
        fall        = r_clk_prev && !in_clk;
        rrise       = !r_rst_prev && in_rst;
        loop_en     = r_ctrl[0];
        mode        = r_ctrl[2:1];
        hold        = r_ctrl[3];
        choke       = r_ctrl[4];
        onehot_mode = (mode == MODE_ONEHOT) || (mode == MODE_ONEHOT_ALT);
        dig_c       = (in_dig > DIGIT_MAX) ? DIGIT_MAX : in_dig;
        sel         = 2'd0;

        c_cur = (r_before || r_stopped) ? 4'd0 : cell_at(r_pos, pat);
        cell0 = cell_at('0, pat);

        // Advance on a clock rise
        if (r_before)       nx = '0;
        else if (r_stopped) nx = PW'(STEPS);
        else                nx = r_pos + PW'(1);
        st1 = 1'b0;
        p1  = nx;
        if (nx >= PW'(STEPS)) begin
            if (loop_en) p1 = '0;
            else begin
                st1 = 1'b1;
                p1  = '0;
            end
        end
        c1      = st1 ? 4'd0 : cell_at(p1, pat);
        end_hit = !st1 && (c1 == CELL_END);
        st2     = st1 || (end_hit && !loop_en);
        p2      = (end_hit && loop_en) ? '0 : p1;
        if (st2)                      v_rise = 4'd0;
        else if (end_hit && loop_en)  v_rise = cell0;
        else                          v_rise = c1;

        // Lap counters advance on landing at step 0
        for (int k = 0; k < 3; k++) begin
            d    = nib(r_lap_div, 2'(k));
            dabs = d[3] ? 4'(~d + 4'd1) : d;
            cnt  = {1'b0, r_lap[k]} + 4'd1;
            if (cnt >= dabs) cnt = 4'd0;
            lap_rise[k] = (!st2 && p2 == '0) ? cnt[2:0] : r_lap[k];
        end

        n_clk_prev = in_clk;
        n_rst_prev = in_rst;
        n_pos      = r_pos;
        n_before   = r_before;
        n_stopped  = r_stopped;
        n_lap      = r_lap;
        n_slice    = r_slice;
        n_main     = r_main;
        n_onehot   = r_onehot;
        n_value    = r_value;
        n_step     = r_step;
        n_loop     = r_loop;
        v          = v_rise;
        lvl        = LVL_OFF;

        if (rise && !rrise) begin
            n_pos     = p2;
            n_before  = 1'b0;
            n_stopped = st2;
            n_lap     = lap_rise;
            // level by cell kind
            case (v)
                KIND_OFF: lvl = LVL_OFF;
                KIND_ON:  lvl = LVL_ON;
                KIND_CHANCE_A, KIND_CHANCE_B, KIND_CHANCE_C: begin
                    sel = 2'(v - KIND_CHANCE_A);
                    lvl = (20'(in_rnd) * TENTHS_SCALE < {nib(r_chance, sel), 16'd0})
                          ? LVL_ON : 7'(v);
                end
                KIND_COIN:
                    lvl = (20'(in_rnd) * TENTHS_SCALE < COIN_THRESH) ? LVL_ON : 7'(v);
                KIND_SLICE: begin
                    lvl     = (DIGIT_BASE + 7'(dig_c)) * LVL_SCALE;
                    n_slice = SW'(SLICE_TICKS);
                end
                KIND_LAP_A, KIND_LAP_B, KIND_LAP_C: begin
                    sel = 2'(v - KIND_LAP_A);
                    d   = nib(r_lap_div, sel);
                    if (d inside {[4'd1:4'd7]})
                        lvl = (lap_rise[sel] == 3'd0) ? LVL_ON : 7'(v);
                    else
                        lvl = (lap_rise[sel] == 3'd0) ? 7'(v) : LVL_ON;
                end
                default: lvl = LVL_OFF;
            endcase
            if (choke && in_nb) lvl = LVL_OFF;
            if (mode == MODE_GATE) n_main = lvl;
            else if (mode == MODE_VALUE)
                n_main = (v <= CELL_END) ? 7'(v) * LVL_SCALE : LVL_OFF;
            else begin
                n_onehot = onehot_of(v);
                n_value  = (v <= CELL_END) ? v : 4'd0;
                n_step   = st2 ? 5'd0 : step_low(p2);
            end
        end else if (rise && rrise) begin
            // reset together with clock: land on step 0
            n_pos     = '0;
            n_before  = 1'b0;
            n_stopped = 1'b0;
            for (int k = 0; k < 3; k++) n_lap[k] = 3'd0;
            n_main = (cell0 != 4'd0) ? LVL_ON : LVL_OFF;
            if (onehot_mode) begin
                n_onehot = onehot_of(cell0);
                n_value  = (cell0 <= CELL_END) ? cell0 : 4'd0;
                n_step   = 5'd0;
            end
        end else if (rrise) begin
            // reset alone: rewind to before start
            n_pos     = '0;
            n_before  = 1'b1;
            n_stopped = 1'b0;
            for (int k = 0; k < 3; k++) n_lap[k] = 3'd0;
            n_main = LVL_OFF;
            if (onehot_mode) n_onehot = 9'd0;
        end else if (mode != MODE_VALUE && c_cur == KIND_COIN && fall) begin
            if (in_rnd < FALL_THRESH) n_main = LVL_OFF;
        end else if (!hold && fall) begin
            n_main = LVL_OFF;
            if (onehot_mode) n_onehot = 9'd0;
        end

        // Slicer gate on the cell now current
        if (rise) v_after = rrise ? cell0 : v_rise;
        else      v_after = rrise ? 4'd0 : c_cur;
        if (mode != MODE_VALUE && v_after == KIND_SLICE) begin
            if (n_slice != '0) n_slice = n_slice - SW'(1);
            if (fall) begin
                n_slice = SW'(SLICE_TICKS);
                n_main  = in_nb ? LVL_OFF : LVL_ON;
            end else if (!rise && n_slice == '0) begin
                n_main = LVL_OFF;
            end
        end

        if (rise) n_loop = !n_before && !n_stopped && (n_pos == '0);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= RST_PATTERN_LO;
            r_pat_hi  <= RST_PATTERN_HI;
            r_ctrl    <= RST_CONTROL;
            r_chance  <= RST_CHANCE;
            r_lap_div <= RST_LAP_DIV;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LO: r_pat_lo  <= i_cfg_data;
                REG_PATTERN_HI: r_pat_hi  <= i_cfg_data;
                REG_CONTROL:    r_ctrl    <= i_cfg_data[4:0];
                REG_CHANCE:     r_chance  <= i_cfg_data[11:0];
                REG_LAP_DIV:    r_lap_div <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // State and held outputs update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_prev <= 1'b0;
            r_rst_prev <= 1'b0;
            r_pos      <= '0;
            r_before   <= 1'b1;
            r_stopped  <= 1'b0;
            for (int k = 0; k < 3; k++) r_lap[k] <= 3'd0;
            r_slice    <= '0;
            r_main     <= LVL_OFF;
            r_onehot   <= 9'd0;
            r_value    <= 4'd0;
            r_step     <= 5'd0;
            r_loop     <= 1'b0;
        end else if (accept) begin
            r_clk_prev <= n_clk_prev;
            r_rst_prev <= n_rst_prev;
            r_pos      <= n_pos;
            r_before   <= n_before;
            r_stopped  <= n_stopped;
            r_lap      <= n_lap;
            r_slice    <= n_slice;
            r_main     <= n_main;
            r_onehot   <= n_onehot;
            r_value    <= n_value;
            r_step     <= n_step;
            r_loop     <= n_loop;
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== tb/tb_probabilistic_trigger_sequencer.sv =====
module tb_probabilistic_trigger_sequencer
    import pts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS       = 32;
    localparam int SLICE_TICKS = 25;
    localparam int PHASE_TICKS = 190;
    localparam int CYCLE_LIMIT = 250000;

    // one input beat, lowest field first from the bottom
    typedef struct packed {
        logic [1:0]  pad;
        logic        nb;
        logic [2:0]  digit;
        logic [15:0] frac;
        logic        rst_lvl;
        logic        clk_lvl;
    } t_tick;

    // one output beat, bits 25:0 of tdata
    typedef struct packed {
        logic       loop;
        logic [4:0] step;
        logic [3:0] value;
        logic [8:0] onehot;
        logic [6:0] main;
    } t_levels;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [0] clock_level, [1] reset_level, [17:2] random_fraction,
    // [20:18] random_digit, [21] neighbour_gate_high
    logic [23:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [6:0] main_level, [15:7] kind_one_hot, [19:16] cell_value,
    // [24:20] step_number, [25] loop_start
    logic [31:0] o_m_axis_tdata;

    probabilistic_trigger_sequencer #(
        .STEPS       (STEPS),
        .SLICE_TICKS (SLICE_TICKS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    t_tick   ticks_pending[$];
    t_levels levels_due[$];
    int      errors = 0;
    int      cycles = 0;
    int      send_gap_pct = 0;
    int      ready_drop_pct = 0;
    bit      s_fire = 1'b0;

    // waveform state of the generated clock and reset levels
    bit      wave_clk = 1'b0;
    bit      wave_rst = 1'b0;
    int      clk_left = 0;
    int      rst_left = 0;

    // predictor: configuration copy
    logic [63:0] pat_lo, pat_hi;
    logic [4:0]  ctrl_reg;
    logic [11:0] chance_reg, lap_div;
    // predictor: sequencer state
    logic        clk_prev, rst_prev, pre_start, halted;
    int          pos;
    int          lap_cnt[3];
    int          slice_cnt;
    t_levels     held;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reset_model();
        pat_lo     = RST_PATTERN_LO;
        pat_hi     = RST_PATTERN_HI;
        ctrl_reg   = RST_CONTROL;
        chance_reg = RST_CHANCE;
        lap_div    = RST_LAP_DIV;
        clk_prev   = 1'b0;
        rst_prev   = 1'b0;
        pre_start  = 1'b1;
        halted     = 1'b0;
        pos        = 0;
        slice_cnt  = 0;
        lap_cnt    = '{0, 0, 0};
        held       = '0;
    endtask

    // cell under the playhead; reads outside the live pattern give 0
    function automatic int cell_at();
        if (pre_start || halted || pos >= STEPS) return 0;
        if (pos < 16) return int'(pat_lo[4*pos +: 4]);
        return int'(pat_hi[4*(pos-16) +: 4]);
    endfunction

    function automatic void show_cell(int v);
        held.onehot = (v >= 1 && v <= 9) ? 9'(1 << (v - 1)) : 9'd0;
        held.value  = (v <= 10) ? 4'(v) : 4'd0;
        held.step   = (pre_start || halted) ? 5'd0 : 5'(pos);
    endfunction

    // advance the sequencer by one sample tick and return the held outputs
    function automatic t_levels predict_levels(t_tick t);
        logic       rise, fall, rrise, loop_on, onehot_on, hold_on, choke_on, zero;
        logic [1:0] mode;
        int         nxt, v, lvl, dig, frac, n, c;
        rise      = !clk_prev && t.clk_lvl;
        fall      = clk_prev && !t.clk_lvl;
        rrise     = !rst_prev && t.rst_lvl;
        loop_on   = ctrl_reg[0];
        mode      = ctrl_reg[2:1];
        onehot_on = (mode == MODE_ONEHOT) || (mode == MODE_ONEHOT_ALT);
        hold_on   = ctrl_reg[3];
        choke_on  = ctrl_reg[4];
        clk_prev  = t.clk_lvl;
        rst_prev  = t.rst_lvl;
        dig       = (t.digit > DIGIT_MAX) ? int'(DIGIT_MAX) : int'(t.digit);
        frac      = int'(t.frac);
        lvl       = 0;

        if (rise && !rrise) begin
            // step forward, wrapping or stopping at the end of the pattern
            if (pre_start) nxt = 0;
            else if (halted) nxt = STEPS;
            else nxt = pos + 1;
            pre_start = 1'b0;
            halted    = 1'b0;
            if (nxt >= STEPS) begin
                if (loop_on) nxt = 0;
                else halted = 1'b1;
            end
            pos = halted ? 0 : nxt;
            if (!halted && cell_at() == CELL_END) begin
                if (loop_on) pos = 0;
                else halted = 1'b1;
            end
            // lap counters tick on every landing on step 0
            if (!halted && pos == 0) begin
                for (int k = 0; k < 3; k++) begin
                    n = int'(lap_div[4*k +: 4]);
                    if (n >= 8) n = 16 - n;
                    c = lap_cnt[k] + 1;
                    if (c >= n) c = 0;
                    lap_cnt[k] = c;
                end
            end
            v = cell_at();
            case (v)
                KIND_OFF: lvl = LVL_OFF;
                KIND_ON:  lvl = LVL_ON;
                KIND_CHANCE_A, KIND_CHANCE_B, KIND_CHANCE_C: begin
                    n   = int'(chance_reg[4*(v - int'(KIND_CHANCE_A)) +: 4]);
                    lvl = (frac * int'(TENTHS_SCALE) < n * 65536) ? int'(LVL_ON) : v;
                end
                KIND_COIN: lvl = (frac * int'(TENTHS_SCALE) < int'(COIN_THRESH))
                                 ? int'(LVL_ON) : v;
                KIND_SLICE: begin
                    lvl       = (int'(DIGIT_BASE) + dig) * int'(LVL_SCALE);
                    slice_cnt = SLICE_TICKS;
                end
                KIND_LAP_A, KIND_LAP_B, KIND_LAP_C: begin
                    n    = int'(lap_div[4*(v - int'(KIND_LAP_A)) +: 4]);
                    zero = (lap_cnt[v - int'(KIND_LAP_A)] == 0);
                    if (n >= 1 && n <= 7) lvl = zero ? int'(LVL_ON) : v;
                    else lvl = zero ? v : int'(LVL_ON);
                end
                default: lvl = LVL_OFF;
            endcase
            if (choke_on && t.nb) lvl = LVL_OFF;
            if (mode == MODE_GATE) held.main = 7'(lvl);
            else if (mode == MODE_VALUE) held.main = (v <= 10) ? 7'(v * 10) : LVL_OFF;
            else show_cell(v);
        end else if (rise && rrise) begin
            // reset together with clock: start on step 0 at once
            pos       = 0;
            pre_start = 1'b0;
            halted    = 1'b0;
            lap_cnt   = '{0, 0, 0};
            v         = cell_at();
            held.main = (v > 0) ? LVL_ON : LVL_OFF;
            if (onehot_on) show_cell(v);
        end else if (rrise) begin
            pos       = 0;
            pre_start = 1'b1;
            halted    = 1'b0;
            lap_cnt   = '{0, 0, 0};
            held.main = LVL_OFF;
            if (onehot_on) held.onehot = '0;
        end else if (mode != MODE_VALUE && cell_at() == KIND_COIN && fall) begin
            if (frac < int'(FALL_THRESH)) held.main = LVL_OFF;
        end else if (!hold_on && fall) begin
            held.main = LVL_OFF;
            if (onehot_on) held.onehot = '0;
        end

        // slicer countdown and retrigger
        if (mode != MODE_VALUE && cell_at() == KIND_SLICE) begin
            if (slice_cnt > 0) slice_cnt--;
            if (fall) begin
                slice_cnt = SLICE_TICKS;
                held.main = t.nb ? LVL_OFF : LVL_ON;
            end else if (!rise && slice_cnt == 0) begin
                held.main = LVL_OFF;
            end
        end

        if (rise) held.loop = !pre_start && !halted && pos == 0;
        return held;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // input driver: a new beat only once the previous one has been taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (s_fire || !i_s_axis_tvalid) begin
                if (ticks_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= ticks_pending.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= ready_drop_pct);
        end
    end

    // monitor: predict on each accepted input beat, check each output beat
    always @(posedge i_clk) begin : monitor
        t_levels want, got;
        s_fire = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (s_fire) levels_due.push_back(predict_levels(t_tick'(i_s_axis_tdata)));
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_levels'(o_m_axis_tdata[25:0]);
            if (levels_due.size() == 0) begin
                errors++;
                $display("%0t: output beat with nothing expected, got %h",
                         $time, o_m_axis_tdata);
            end else begin
                want = levels_due.pop_front();
                check_field("main_level",   want.main,   got.main);
                check_field("kind_one_hot", want.onehot, got.onehot);
                check_field("cell_value",   want.value,  got.value);
                check_field("step_number",  want.step,   got.step);
                check_field("loop_start",   want.loop,   got.loop);
            end
        end
    end

    task automatic push_tick(bit clk_lvl, bit rst_lvl, int frac, int dig, bit nb);
        t_tick t;
        t.pad     = '0;
        t.clk_lvl = clk_lvl;
        t.rst_lvl = rst_lvl;
        t.frac    = 16'(frac);
        t.digit   = 3'(dig);
        t.nb      = nb;
        ticks_pending.push_back(t);
    endtask

    // clock and reset waveforms with random content, a little noise mixed in
    task automatic queue_ticks(int count);
        int f, n;
        bit ck, rs;
        repeat (count) begin
            if (clk_left == 0) begin
                wave_clk = !wave_clk;
                n = $urandom_range(99);
                if (n < 80) clk_left = $urandom_range(1, 3);
                else if (n < 95) clk_left = $urandom_range(4, 8);
                else clk_left = $urandom_range(20, 40);
            end
            clk_left--;
            if (wave_rst) begin
                if (rst_left == 0) wave_rst = 1'b0;
                else rst_left--;
            end else if ($urandom_range(99) < 2) begin
                wave_rst = 1'b1;
                rst_left = $urandom_range(3);
            end
            ck = wave_clk;
            rs = wave_rst;
            if ($urandom_range(99) < 4) begin
                ck = $urandom_range(1);
                rs = $urandom_range(1);
            end
            // fraction: extremes and values around every threshold
            case ($urandom_range(9))
                0: f = 0;
                1: f = 65535;
                2: f = 39321 + $urandom_range(1);
                3: f = 32767 + $urandom_range(1);
                4: begin
                    n = $urandom_range(15);
                    f = (n * 65536 + 9) / 10 - int'($urandom_range(1));
                    if (f < 0) f = 0;
                    if (f > 65535) f = 65535;
                end
                default: f = $urandom_range(65535);
            endcase
            push_tick(ck, rs, f, $urandom_range(7), $urandom_range(99) < 30);
        end
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_PATTERN_LO: pat_lo     = val;
            REG_PATTERN_HI: pat_hi     = val;
            REG_CONTROL:    ctrl_reg   = val[4:0];
            REG_CHANCE:     chance_reg = val[11:0];
            REG_LAP_DIV:    lap_div    = val[11:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [127:0] pat, logic [4:0] ctrl,
                              logic [11:0] chance, logic [11:0] laps);
        write_reg(REG_PATTERN_LO, pat[63:0]);
        write_reg(REG_PATTERN_HI, pat[127:64]);
        write_reg(REG_CONTROL, 64'(ctrl));
        write_reg(REG_CHANCE, 64'(chance));
        write_reg(REG_LAP_DIV, 64'(laps));
    endtask

    // random pattern, end marker at end_at (none when end_at >= 32)
    function automatic logic [127:0] rand_pattern(int end_at);
        logic [127:0] p;
        for (int i = 0; i < 32; i++) begin
            if (i == end_at) p[4*i +: 4] = CELL_END;
            else if ($urandom_range(99) < 8) p[4*i +: 4] = 4'($urandom_range(11, 15));
            else p[4*i +: 4] = 4'($urandom_range(9));
        end
        return p;
    endfunction

    task automatic wait_idle();
        while (ticks_pending.size() != 0 || i_s_axis_tvalid || levels_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [127:0] pat;
        reset_model();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 3) begin
                send_gap_pct   = 8;
                ready_drop_pct = 61;
            end else if (ph < 6) begin
                send_gap_pct   = 61;
                ready_drop_pct = 8;
            end else begin
                send_gap_pct   = 0;
                ready_drop_pct = 0;
            end
            case (ph)
                0: begin
                    // defaults after reset: extremes of fields, reset cases
                    push_tick(0, 0, 0, 0, 0);
                    push_tick(1, 0, 0, 0, 0);
                    push_tick(0, 0, 65535, 7, 1);
                    push_tick(1, 0, 65535, 7, 1);
                    push_tick(1, 1, 0, 0, 0);
                    push_tick(0, 1, 39321, 6, 0);
                    push_tick(1, 0, 39322, 0, 1);
                    push_tick(0, 0, 32767, 3, 0);
                    push_tick(1, 1, 32768, 5, 1);
                    push_tick(0, 0, 1, 1, 0);
                    push_tick(0, 1, 65534, 2, 1);
                    push_tick(0, 0, 2, 4, 0);
                    push_tick(1, 0, 6553, 7, 0);
                    push_tick(0, 0, 6554, 0, 1);
                    push_tick(1, 0, 12345, 6, 1);
                    push_tick(0, 0, 54321, 1, 0);
                end
                // every kind in order, looping, gate mode with choke
                1: set_config({64'($urandom()) << 32 | 64'($urandom()),
                               64'hAFED_CB09_8765_4321},
                              5'b10001, 12'hF5A, 12'h0E3);
                2: begin
                    // same pattern, stop at end, one-hot mode with hold
                    pat = rand_pattern(40);
                    pat[63:0] = 64'hAFED_CB09_8765_4321;
                    set_config(pat, 5'b01010, 12'h000, 12'h888);
                end
                3: set_config(rand_pattern($urandom_range(1, 8)), 5'b00101,
                              12'($urandom()), 12'($urandom()));
                4: set_config({128{1'b1}}, 5'b11111, 12'hFFF, 12'hFFF);
                5: begin
                    pat = rand_pattern(40);
                    pat[63:0] = '0;
                    set_config(pat, 5'b00000, 12'h000, 12'h000);
                end
                6: begin
                    pat = rand_pattern(1);
                    pat[3:0] = 4'($urandom_range(9));
                    set_config(pat, 5'b00001, 12'($urandom()), 12'($urandom()));
                end
                7: begin
                    // end marker on the very first cell
                    pat = rand_pattern(0);
                    set_config(pat, 5'($urandom() | 1), 12'($urandom()), 12'($urandom()));
                end
                default: begin
                    pat = rand_pattern($urandom_range(99) < 70 ? $urandom_range(1, 6)
                                                               : $urandom_range(7, 40));
                    set_config(pat, 5'($urandom()), 12'($urandom()), 12'($urandom()));
                end
            endcase
            queue_ticks(PHASE_TICKS);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (levels_due.size() != 0) begin
            errors++;
            $display("%0t: %0d expected beats never arrived", $time, levels_due.size());
        end
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
